// File: hw/rtl/lanim_pkg.sv
// Shared types, event codes and register defaults for the layered LED animation engine.
// Used by lanim_cfg, lanim_core and the top level; depends on nothing else.
`default_nettype none

package lanim_pkg;

    localparam int unsigned MODE_W    = 3;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned EFFECT_W  = 3;
    localparam int unsigned LED_W     = 3;
    localparam int unsigned IVL_W     = 16;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned FPHASE_W  = 5;
    localparam int unsigned BPHASE_W  = 2;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Event kinds.
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LIGHT_ON  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LIGHT_OFF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALL_OFF   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DIRECT    = 3'd5;

    // Effect codes.
    localparam logic [EFFECT_W-1:0] EFF_OFF       = 3'd0;
    localparam logic [EFFECT_W-1:0] EFF_STATIC    = 3'd1;
    localparam logic [EFFECT_W-1:0] EFF_ADVERTISE = 3'd2;
    localparam logic [EFFECT_W-1:0] EFF_MARQUEE   = 3'd3;
    localparam logic [EFFECT_W-1:0] EFF_BLINK     = 3'd4;
    localparam logic [EFFECT_W-1:0] EFF_CONNECTED = 3'd5;
    localparam logic [EFFECT_W-1:0] EFF_NOTIFY    = 3'd6;
    localparam logic [EFFECT_W-1:0] EFF_OFF_ALT   = 3'd7;

    // Background kinds.
    localparam logic [KIND_W-1:0] KIND_OFF     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STATIC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLINK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MARQUEE = 2'd3;

    localparam logic [LED_W-1:0] LEDS_ALL  = 3'b111;
    localparam logic [LED_W-1:0] LEDS_NONE = 3'b000;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MARQUEE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_BLINK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONN_BLINK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_BLINK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONESHOT_CNT  = 3'd4;

    localparam logic [IVL_W-1:0]   DEF_MARQUEE_STEP = 16'd300;
    localparam logic [IVL_W-1:0]   DEF_SLOW_BLINK   = 16'd500;
    localparam logic [IVL_W-1:0]   DEF_CONN_BLINK   = 16'd200;
    localparam logic [IVL_W-1:0]   DEF_NOTIFY_BLINK = 16'd100;
    localparam logic [COUNT_W-1:0] DEF_ONESHOT_CNT  = 4'd2;

    typedef struct packed {
        logic [IVL_W-1:0]   marquee_step_ms;
        logic [IVL_W-1:0]   slow_blink_ms;
        logic [IVL_W-1:0]   connected_blink_ms;
        logic [IVL_W-1:0]   notify_blink_ms;
        logic [COUNT_W-1:0] oneshot_blinks;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [TIME_W-1:0]   now_ms;
        logic [EFFECT_W-1:0] effect;
        logic [LED_W-1:0]    direct_leds;
    } t_event;

    typedef struct packed {
        logic [LED_W-1:0] led_levels;
        logic             flashlight_on;
        logic             any_active;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/lanim_cfg.sv
// Configuration register file: intervals and one-shot blink count.
// Depends on lanim_pkg for the register indexes and reset defaults.
`default_nettype none

module lanim_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lanim_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lanim_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lanim_pkg::t_cfg                         o_cfg
);
    import lanim_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marquee_step_ms    <= DEF_MARQUEE_STEP;
            r_cfg.slow_blink_ms      <= DEF_SLOW_BLINK;
            r_cfg.connected_blink_ms <= DEF_CONN_BLINK;
            r_cfg.notify_blink_ms    <= DEF_NOTIFY_BLINK;
            r_cfg.oneshot_blinks     <= DEF_ONESHOT_CNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MARQUEE_STEP: r_cfg.marquee_step_ms    <= i_cfg_data;
                REG_SLOW_BLINK:   r_cfg.slow_blink_ms      <= i_cfg_data;
                REG_CONN_BLINK:   r_cfg.connected_blink_ms <= i_cfg_data;
                REG_NOTIFY_BLINK: r_cfg.notify_blink_ms    <= i_cfg_data;
                REG_ONESHOT_CNT:  r_cfg.oneshot_blinks     <= i_cfg_data[COUNT_W-1:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/lanim_core.sv
// Layer state machine: foreground one-shot, background animation, flashlight and LED state.
// Depends on lanim_pkg; updates its state once for every event that the top level hands in.
`default_nettype none

module lanim_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire lanim_pkg::t_event i_evt,
    input  wire lanim_pkg::t_cfg   i_cfg,
    output lanim_pkg::t_result     o_res
);
    import lanim_pkg::*;

    logic                r_flash;
    logic                r_fore_act;
    logic                r_fore_sel;
    logic [FPHASE_W-1:0] r_fore_phase;
    logic [TIME_W-1:0]   r_fore_last;
    logic [KIND_W-1:0]   r_back_kind;
    logic [BPHASE_W-1:0] r_back_phase;
    logic [TIME_W-1:0]   r_back_last;
    logic [LED_W-1:0]    r_led;
    logic                r_any;

    logic                n_flash;
    logic                n_fore_act;
    logic                n_fore_sel;
    logic [FPHASE_W-1:0] n_fore_phase;
    logic [TIME_W-1:0]   n_fore_last;
    logic [KIND_W-1:0]   n_back_kind;
    logic [BPHASE_W-1:0] n_back_phase;
    logic [TIME_W-1:0]   n_back_last;
    logic [LED_W-1:0]    n_led;

    logic [IVL_W-1:0]    fore_ivl;
    logic [IVL_W-1:0]    back_ivl;
    logic [TIME_W-1:0]   fore_elapsed;
    logic [TIME_W-1:0]   back_elapsed;
    logic                fore_due;
    logic                back_due;
    logic [FPHASE_W-1:0] fore_limit;
    logic                count_nz;
    logic [FPHASE_W-1:0] fore_phase_inc;
    logic                fore_done_now;
    logic                fore_done_step;
    logic [BPHASE_W-1:0] marquee_next;

    function automatic logic [LED_W-1:0] marquee_frame(input logic [BPHASE_W-1:0] idx);
        logic [LED_W-1:0] f;
        unique case (idx)
            2'd0:    f = 3'b001;
            2'd1:    f = 3'b010;
            2'd2:    f = 3'b100;
            default: f = 3'b001;
        endcase
        return f;
    endfunction

    function automatic logic [LED_W-1:0] first_frame(input logic [KIND_W-1:0] kind);
        logic [LED_W-1:0] f;
        unique case (kind)
            KIND_OFF:     f = LEDS_NONE;
            KIND_MARQUEE: f = marquee_frame(2'd0);
            default:      f = LEDS_ALL;
        endcase
        return f;
    endfunction

    function automatic logic [KIND_W-1:0] effect_kind(input logic [EFFECT_W-1:0] eff);
        logic [KIND_W-1:0] k;
        unique case (eff)
            EFF_STATIC:                 k = KIND_STATIC;
            EFF_ADVERTISE, EFF_MARQUEE: k = KIND_MARQUEE;
            EFF_BLINK:                  k = KIND_BLINK;
            default:                    k = KIND_OFF;
        endcase
        return k;
    endfunction

    // Elapsed times wrap modulo 2^32, so a plain subtraction is enough.
    assign fore_ivl       = r_fore_sel ? i_cfg.notify_blink_ms : i_cfg.connected_blink_ms;
    assign back_ivl       = (r_back_kind == KIND_BLINK) ? i_cfg.slow_blink_ms
                                                        : i_cfg.marquee_step_ms;
    assign fore_elapsed   = i_evt.now_ms - r_fore_last;
    assign back_elapsed   = i_evt.now_ms - r_back_last;
    assign fore_due       = fore_elapsed >= {{(TIME_W-IVL_W){1'b0}}, fore_ivl};
    assign back_due       = back_elapsed >= {{(TIME_W-IVL_W){1'b0}}, back_ivl};
    assign fore_limit     = {i_cfg.oneshot_blinks, 1'b0};
    assign count_nz       = i_cfg.oneshot_blinks != '0;
    assign fore_phase_inc = r_fore_phase + FPHASE_W'(1);
    assign fore_done_now  = count_nz && (r_fore_phase >= fore_limit);
    assign fore_done_step = count_nz && (fore_phase_inc >= fore_limit);

    always_comb begin
        unique case (r_back_phase)
            2'd0:    marquee_next = 2'd1;
            2'd1:    marquee_next = 2'd2;
            2'd2:    marquee_next = 2'd0;
            default: marquee_next = 2'd1;
        endcase
    end

    always_comb begin
        n_flash      = r_flash;
        n_fore_act   = r_fore_act;
        n_fore_sel   = r_fore_sel;
        n_fore_phase = r_fore_phase;
        n_fore_last  = r_fore_last;
        n_back_kind  = r_back_kind;
        n_back_phase = r_back_phase;
        n_back_last  = r_back_last;
        n_led        = r_led;

        unique case (i_evt.mode)
            MODE_TICK: begin
                if (r_flash) begin
                    n_led = LEDS_ALL;
                end else if (r_fore_act) begin
                    // A finished one-shot hands the LEDs back to a restarted background.
                    if (fore_done_now || (fore_due && fore_done_step)) begin
                        n_fore_act   = 1'b0;
                        n_back_phase = '0;
                        n_back_last  = i_evt.now_ms;
                        n_led        = first_frame(r_back_kind);
                        if (!fore_done_now) begin
                            n_fore_phase = fore_phase_inc;
                            n_fore_last  = i_evt.now_ms;
                        end
                    end else if (fore_due) begin
                        n_fore_phase = fore_phase_inc;
                        n_fore_last  = i_evt.now_ms;
                        n_led        = fore_phase_inc[0] ? LEDS_NONE : LEDS_ALL;
                    end
                end else if (back_due) begin
                    if (r_back_kind == KIND_BLINK) begin
                        n_back_last  = i_evt.now_ms;
                        n_back_phase = {1'b0, ~r_back_phase[0]};
                        n_led        = r_back_phase[0] ? LEDS_ALL : LEDS_NONE;
                    end else if (r_back_kind == KIND_MARQUEE) begin
                        n_back_last  = i_evt.now_ms;
                        n_back_phase = marquee_next;
                        n_led        = marquee_frame(marquee_next);
                    end
                end
            end
            MODE_SET: begin
                if (i_evt.effect == EFF_CONNECTED || i_evt.effect == EFF_NOTIFY) begin
                    n_fore_act   = 1'b1;
                    n_fore_sel   = i_evt.effect == EFF_NOTIFY;
                    n_fore_phase = '0;
                    n_fore_last  = i_evt.now_ms;
                    n_led        = LEDS_ALL;
                end else begin
                    n_fore_act   = 1'b0;
                    n_back_kind  = effect_kind(i_evt.effect);
                    n_back_phase = '0;
                    n_back_last  = i_evt.now_ms;
                    n_led        = first_frame(effect_kind(i_evt.effect));
                end
            end
            MODE_LIGHT_ON: begin
                n_flash = 1'b1;
                n_led   = LEDS_ALL;
            end
            MODE_LIGHT_OFF: begin
                n_flash = 1'b0;
                if (!r_fore_act) begin
                    n_back_phase = '0;
                    n_back_last  = i_evt.now_ms;
                    n_led        = first_frame(r_back_kind);
                end
            end
            MODE_ALL_OFF: begin
                n_flash      = 1'b0;
                n_fore_act   = 1'b0;
                n_back_kind  = KIND_OFF;
                n_back_phase = '0;
                n_back_last  = i_evt.now_ms;
                n_led        = LEDS_NONE;
            end
            MODE_DIRECT: begin
                if (!r_flash) begin
                    n_led = i_evt.direct_leds;
                end
            end
            default: begin
                // Unused event kinds only report the current state.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash      <= 1'b0;
            r_fore_act   <= 1'b0;
            r_fore_sel   <= 1'b0;
            r_fore_phase <= '0;
            r_fore_last  <= '0;
            r_back_kind  <= KIND_OFF;
            r_back_phase <= '0;
            r_back_last  <= '0;
            r_led        <= LEDS_NONE;
            r_any        <= 1'b0;
        end else if (i_fire) begin
            r_flash      <= n_flash;
            r_fore_act   <= n_fore_act;
            r_fore_sel   <= n_fore_sel;
            r_fore_phase <= n_fore_phase;
            r_fore_last  <= n_fore_last;
            r_back_kind  <= n_back_kind;
            r_back_phase <= n_back_phase;
            r_back_last  <= n_back_last;
            r_led        <= n_led;
            r_any        <= n_flash | n_fore_act | (n_back_kind != KIND_OFF);
        end
    end

    assign o_res.led_levels    = r_led;
    assign o_res.flashlight_on = r_flash;
    assign o_res.any_active    = r_any;

    a_light_on_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_evt.mode == MODE_LIGHT_ON) |=> (r_led == LEDS_ALL && r_flash))
        else $error("flashlight on did not light all LEDs");

    a_all_off_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_evt.mode == MODE_ALL_OFF) |=> (r_led == LEDS_NONE && !r_any))
        else $error("all-off left a layer active");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_led) && $stable(r_fore_phase) && $stable(r_back_kind)))
        else $error("layer state changed without an event");

    a_back_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_back_kind == KIND_BLINK) |-> (r_back_phase[1] == 1'b0))
        else $error("blink phase out of range");

endmodule

`default_nettype wire

// File: hw/rtl/layered_led_animation_engine.sv
// Layered LED animation engine, top level: input register, layer core, result handshake.
// An event is held in the input register, then its result is registered in the core state; a stalled output holds it.
// Throughput: one event per cycle while the output is not stalled; the core updates its state once per event.
// While a result waits on a stalled output, the input register holds one more event, then stalls.
// Reset (synchronous, active low) clears all layers and LEDs and restores register defaults.
// Depends on lanim_pkg, lanim_cfg and lanim_core.
`default_nettype none

module layered_led_animation_engine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [lanim_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [lanim_pkg::TIME_W-1:0]        i_now_ms,
    input  wire logic [lanim_pkg::EFFECT_W-1:0]      i_effect,
    input  wire logic [lanim_pkg::LED_W-1:0]         i_direct_leds,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [lanim_pkg::LED_W-1:0]              o_led_levels,
    output logic                                     o_flashlight_on,
    output logic                                     o_any_active,
    input  wire logic                                i_cfg_we,
    input  wire logic [lanim_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lanim_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lanim_pkg::*;

    t_event  r_in;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    fire;
    logic    in_xfer;
    t_cfg    cfg;
    t_result res;

    // The core updates when an event is held and the result slot is free or being drained.
    assign fire       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !fire;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.mode        <= i_mode;
            r_in.now_ms      <= i_now_ms;
            r_in.effect      <= i_effect;
            r_in.direct_leds <= i_direct_leds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    lanim_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lanim_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_evt   (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign o_out_valid     = r_out_vld;
    assign o_led_levels    = res.led_levels;
    assign o_flashlight_on = res.flashlight_on;
    assign o_any_active    = res.any_active;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("processed event produced no result");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_in_stall)
        else $error("input stalled with an empty input register");

    a_flash_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_flashlight_on || o_any_active))
        else $error("flashlight reported without activity flag");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_led_levels)))
        else $error("stalled result transfer changed");

endmodule

`default_nettype wire

// File: bench/lanim_layer_checker.sv
// Checker for the layered LED animation engine: watches the event, result and register ports,
// keeps its own copy of the layer state to predict every result, and compares all fields at once.
// Depends on lanim_pkg.
module lanim_layer_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  wire logic [lanim_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [lanim_pkg::TIME_W-1:0]     i_now_ms,
    input  wire logic [lanim_pkg::EFFECT_W-1:0]   i_effect,
    input  wire logic [lanim_pkg::LED_W-1:0]      i_direct_leds,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic [lanim_pkg::LED_W-1:0]      i_led_levels,
    input  wire logic                             i_flashlight_on,
    input  wire logic                             i_any_active,
    input  wire logic                             i_cfg_we,
    input  wire logic [lanim_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lanim_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                    o_mismatches,
    output int                                    o_outstanding
);
    import lanim_pkg::*;

    t_cfg                cfg;
    logic                flash_on;
    logic                fg_active;
    logic                fg_notify;
    logic [FPHASE_W-1:0] fg_phase;
    logic [TIME_W-1:0]   fg_last;
    logic [KIND_W-1:0]   bg_kind;
    logic [BPHASE_W-1:0] bg_phase;
    logic [TIME_W-1:0]   bg_last;
    logic [LED_W-1:0]    leds;

    t_result predicted_outputs[$];
    t_event  arrived;
    t_result seen;
    t_result want;
    int      mismatch_count = 0;

    function automatic logic [LED_W-1:0] chase_pattern(input logic [BPHASE_W-1:0] idx);
        return LED_W'(1) << (idx % 3);
    endfunction

    function automatic void restart_background(input logic [KIND_W-1:0] kind,
                                               input logic [TIME_W-1:0] now);
        bg_kind  = kind;
        bg_phase = '0;
        bg_last  = now;
        case (kind)
            KIND_OFF:     leds = LEDS_NONE;
            KIND_MARQUEE: leds = chase_pattern('0);
            default:      leds = LEDS_ALL;
        endcase
    endfunction

    function automatic void advance_background(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - bg_last;
        if (bg_kind == KIND_BLINK && elapsed >= TIME_W'(cfg.slow_blink_ms)) begin
            bg_last  = now;
            bg_phase = {1'b0, ~bg_phase[0]};
            leds     = bg_phase[0] ? LEDS_NONE : LEDS_ALL;
        end else if (bg_kind == KIND_MARQUEE && elapsed >= TIME_W'(cfg.marquee_step_ms)) begin
            bg_last  = now;
            bg_phase = (bg_phase >= 2) ? '0 : bg_phase + 1'b1;
            leds     = chase_pattern(bg_phase);
        end
    endfunction

    // Returns zero when the one-shot has just finished. A blink count of zero never finishes.
    function automatic logic advance_foreground(input logic [TIME_W-1:0] now);
        int unsigned       limit;
        logic [IVL_W-1:0]  interval;
        logic [TIME_W-1:0] elapsed;
        limit    = 2 * cfg.oneshot_blinks;
        interval = fg_notify ? cfg.notify_blink_ms : cfg.connected_blink_ms;
        elapsed  = now - fg_last;
        if (cfg.oneshot_blinks != 0 && fg_phase >= limit) begin
            leds      = LEDS_NONE;
            fg_active = 1'b0;
            return 1'b0;
        end
        if (elapsed >= TIME_W'(interval)) begin
            fg_last  = now;
            fg_phase = fg_phase + 1'b1;
            if (cfg.oneshot_blinks != 0 && fg_phase >= limit) begin
                leds      = LEDS_NONE;
                fg_active = 1'b0;
                return 1'b0;
            end
            leds = fg_phase[0] ? LEDS_NONE : LEDS_ALL;
        end
        return 1'b1;
    endfunction

    function automatic t_result step_layers(input t_event ev);
        t_result           r;
        logic [KIND_W-1:0] kind;
        case (ev.mode)
            MODE_TICK: begin
                if (flash_on) begin
                    leds = LEDS_ALL;
                end else if (fg_active) begin
                    if (!advance_foreground(ev.now_ms))
                        restart_background(bg_kind, ev.now_ms);
                end else begin
                    advance_background(ev.now_ms);
                end
            end
            MODE_SET: begin
                if (ev.effect == EFF_CONNECTED || ev.effect == EFF_NOTIFY) begin
                    fg_active = 1'b1;
                    fg_notify = (ev.effect == EFF_NOTIFY);
                    fg_phase  = '0;
                    fg_last   = ev.now_ms;
                    leds      = LEDS_ALL;
                end else begin
                    case (ev.effect)
                        EFF_STATIC:                 kind = KIND_STATIC;
                        EFF_ADVERTISE, EFF_MARQUEE: kind = KIND_MARQUEE;
                        EFF_BLINK:                  kind = KIND_BLINK;
                        default:                    kind = KIND_OFF;
                    endcase
                    fg_active = 1'b0;
                    restart_background(kind, ev.now_ms);
                end
            end
            MODE_LIGHT_ON: begin
                flash_on = 1'b1;
                leds     = LEDS_ALL;
            end
            MODE_LIGHT_OFF: begin
                flash_on = 1'b0;
                if (!fg_active)
                    restart_background(bg_kind, ev.now_ms);
            end
            MODE_ALL_OFF: begin
                flash_on  = 1'b0;
                fg_active = 1'b0;
                restart_background(KIND_OFF, ev.now_ms);
            end
            MODE_DIRECT: begin
                if (!flash_on)
                    leds = ev.direct_leds;
            end
            default: ;
        endcase
        r.led_levels    = leds;
        r.flashlight_on = flash_on;
        r.any_active    = flash_on || fg_active || bg_kind != KIND_OFF;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '{DEF_MARQUEE_STEP, DEF_SLOW_BLINK, DEF_CONN_BLINK, DEF_NOTIFY_BLINK,
                    DEF_ONESHOT_CNT};
            flash_on  = 1'b0;
            fg_active = 1'b0;
            fg_notify = 1'b0;
            fg_phase  = '0;
            fg_last   = '0;
            bg_kind   = KIND_OFF;
            bg_phase  = '0;
            bg_last   = '0;
            leds      = LEDS_NONE;
            predicted_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MARQUEE_STEP: cfg.marquee_step_ms    = i_cfg_data;
                    REG_SLOW_BLINK:   cfg.slow_blink_ms      = i_cfg_data;
                    REG_CONN_BLINK:   cfg.connected_blink_ms = i_cfg_data;
                    REG_NOTIFY_BLINK: cfg.notify_blink_ms    = i_cfg_data;
                    REG_ONESHOT_CNT:  cfg.oneshot_blinks     = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen = '{led_levels: i_led_levels, flashlight_on: i_flashlight_on,
                         any_active: i_any_active};
                if (predicted_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no event waiting: leds %b flash %b active %b",
                                 $time, seen.led_levels, seen.flashlight_on, seen.any_active);
                end else begin
                    want = predicted_outputs.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch: expected leds %b flash %b active %b,",
                                      " got leds %b flash %b active %b"},
                                     $time, want.led_levels, want.flashlight_on,
                                     want.any_active, seen.led_levels, seen.flashlight_on,
                                     seen.any_active);
                    end
                end
            end
            // Results come out in event order, so the prediction is queued at the event transfer.
            if (i_in_valid && !i_in_stall) begin
                arrived = '{mode: i_mode, now_ms: i_now_ms, effect: i_effect,
                            direct_leds: i_direct_leds};
                predicted_outputs.push_back(step_layers(arrived));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= predicted_outputs.size();
    end

endmodule

// File: bench/tb.sv
// Top of the bench for layered_led_animation_engine: clock, reset, event stimulus, register
// settings, receiver stalls and the verdict. Depends on lanim_pkg and lanim_layer_checker.
module tb;
    import lanim_pkg::*;

    localparam int unsigned ITEMS_PER_SEGMENT = 240;
    localparam int unsigned SEGMENTS          = 7;
    localparam int unsigned WATCHDOG_LIMIT    = 2000;

    // Event kinds and register slots the block has no use for.
    localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  ev_valid  = 1'b0;
    logic                  ev_stall;
    t_event                ev_data   = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [LED_W-1:0]      res_leds;
    logic                  res_flash;
    logic                  res_active;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          mismatches;
    int          outstanding;
    int unsigned quiet_cycles       = 0;
    int unsigned sender_idle_pct    = 37;
    int unsigned receiver_stall_pct = 59;
    int unsigned items_sent;
    logic [TIME_W-1:0] clock_ms = 32'hFFFF_FFF0;
    t_cfg        live_cfg;
    t_cfg        plan [SEGMENTS];

    always #4 clk = ~clk;

    layered_led_animation_engine dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (ev_valid),
        .o_in_stall      (ev_stall),
        .i_mode          (ev_data.mode),
        .i_now_ms        (ev_data.now_ms),
        .i_effect        (ev_data.effect),
        .i_direct_leds   (ev_data.direct_leds),
        .o_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .o_led_levels    (res_leds),
        .o_flashlight_on (res_flash),
        .o_any_active    (res_active),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    lanim_layer_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (ev_valid),
        .i_in_stall      (ev_stall),
        .i_mode          (ev_data.mode),
        .i_now_ms        (ev_data.now_ms),
        .i_effect        (ev_data.effect),
        .i_direct_leds   (ev_data.direct_leds),
        .i_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .i_led_levels    (res_leds),
        .i_flashlight_on (res_flash),
        .i_any_active    (res_active),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Any transfer or register write counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (ev_valid && !ev_stall) || (res_valid && !res_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Handshake signals settle after the rising edge, so they are sampled at the falling edge.
    task automatic emit(input logic [MODE_W-1:0] m, input logic [EFFECT_W-1:0] fx,
                        input logic [LED_W-1:0] dl, input logic [TIME_W-1:0] delta);
        logic taken;
        clock_ms = clock_ms + delta;
        while ($urandom_range(99) < sender_idle_pct) begin
            ev_valid <= 1'b0;
            @(posedge clk);
        end
        ev_valid <= 1'b1;
        ev_data  <= '{mode: m, now_ms: clock_ms, effect: fx, direct_leds: dl};
        do begin
            @(negedge clk);
            taken = !ev_stall;
            @(posedge clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic wait_drained();
        ev_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input t_cfg c);
        logic [CFG_DATA_W-1:0] count_word;
        // The count register only keeps its low bits; the upper bits carry noise.
        count_word                = CFG_DATA_W'($urandom);
        count_word[COUNT_W-1:0]   = c.oneshot_blinks;
        put_reg(REG_MARQUEE_STEP, c.marquee_step_ms);
        put_reg(REG_SLOW_BLINK, c.slow_blink_ms);
        put_reg(REG_CONN_BLINK, c.connected_blink_ms);
        put_reg(REG_NOTIFY_BLINK, c.notify_blink_ms);
        put_reg(REG_ONESHOT_CNT, count_word);
        put_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        put_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_we   <= 1'b0;
        live_cfg = c;
    endtask

    // Time advance between events, mostly on the scale of one of the live intervals.
    function automatic logic [TIME_W-1:0] time_step();
        logic [IVL_W-1:0] ivl;
        case ($urandom_range(3))
            0:       ivl = live_cfg.marquee_step_ms;
            1:       ivl = live_cfg.slow_blink_ms;
            2:       ivl = live_cfg.connected_blink_ms;
            default: ivl = live_cfg.notify_blink_ms;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(2 * ivl + 1);
            4, 5:       return TIME_W'(ivl) + $urandom_range(2) - 1;
            6, 7:       return $urandom_range(3);
            8:          return $urandom;
            default:    return '0;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 25)
            return MODE_SET;
        else if (p < 40)
            return MODE_LIGHT_ON;
        else if (p < 55)
            return MODE_LIGHT_OFF;
        else if (p < 65)
            return MODE_ALL_OFF;
        else if (p < 90)
            return MODE_DIRECT;
        else if (p < 95)
            return MODE_SPARE_LO;
        else
            return MODE_SPARE_HI;
    endfunction

    initial begin : stimulus
        int unsigned seg;
        int unsigned run;

        live_cfg = '{DEF_MARQUEE_STEP, DEF_SLOW_BLINK, DEF_CONN_BLINK, DEF_NOTIFY_BLINK,
                     DEF_ONESHOT_CNT};
        plan[0] = '{16'd1, 16'd1, 16'd1, 16'd1, 4'd1};
        plan[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15};
        plan[2] = '{16'd0, 16'd0, 16'd0, 16'd0, 4'd0};
        plan[3] = '{IVL_W'($urandom_range(1000, 1)), IVL_W'($urandom_range(1000, 1)),
                    IVL_W'($urandom_range(1000, 1)), IVL_W'($urandom_range(1000, 1)), 4'd15};
        plan[4] = '{IVL_W'($urandom_range(1000, 1)), IVL_W'($urandom_range(1000, 1)),
                    IVL_W'($urandom_range(1000, 1)), IVL_W'($urandom_range(1000, 1)), 4'd1};
        plan[5] = '{IVL_W'($urandom), IVL_W'($urandom), IVL_W'($urandom), IVL_W'($urandom),
                    COUNT_W'($urandom)};
        plan[6] = live_cfg;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset settings, starting just below the time wrap.
        emit(MODE_TICK, EFF_OFF, LEDS_NONE, 0);
        emit(MODE_SPARE_LO, EFF_OFF_ALT, LEDS_ALL, 1);
        emit(MODE_SPARE_HI, EFF_OFF_ALT, LEDS_ALL, 1);
        emit(MODE_SET, EFF_STATIC, LEDS_NONE, 2);
        emit(MODE_SET, EFF_ADVERTISE, LEDS_NONE, 3);
        emit(MODE_TICK, EFF_OFF, LEDS_NONE, TIME_W'(DEF_MARQUEE_STEP) - TIME_W'(1));
        emit(MODE_TICK, EFF_OFF, LEDS_NONE, 1);
        emit(MODE_SET, EFF_MARQUEE, LEDS_NONE, 5);
        emit(MODE_TICK, EFF_OFF, LEDS_NONE, TIME_W'(DEF_MARQUEE_STEP));
        emit(MODE_SET, EFF_BLINK, LEDS_NONE, 7);
        emit(MODE_TICK, EFF_OFF, LEDS_NONE, TIME_W'(DEF_SLOW_BLINK));
        // Connected one-shot runs to its end and hands back to the blinking background.
        emit(MODE_SET, EFF_CONNECTED, LEDS_NONE, 1);
        repeat (4) emit(MODE_TICK, EFF_OFF, LEDS_NONE, TIME_W'(DEF_CONN_BLINK));
        // Flashlight over an active one-shot: direct write is ignored, the one-shot resumes.
        emit(MODE_SET, EFF_NOTIFY, LEDS_NONE, 1);
        emit(MODE_LIGHT_ON, EFF_OFF, LEDS_NONE, 1);
        emit(MODE_TICK, EFF_OFF, LEDS_NONE, TIME_W'(DEF_NOTIFY_BLINK));
        emit(MODE_DIRECT, EFF_OFF, LEDS_ALL, 0);
        emit(MODE_LIGHT_OFF, EFF_OFF, LEDS_NONE, 0);
        emit(MODE_TICK, EFF_OFF, LEDS_NONE, TIME_W'(DEF_NOTIFY_BLINK));
        emit(MODE_ALL_OFF, EFF_OFF, LEDS_NONE, 3);
        emit(MODE_DIRECT, EFF_OFF, 3'b101, 0);
        emit(MODE_SET, EFF_OFF_ALT, LEDS_NONE, 1);
        emit(MODE_LIGHT_OFF, EFF_OFF, LEDS_NONE, 1);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 2) begin
                sender_idle_pct    = 59;
                receiver_stall_pct <= 37;
            end else if (seg == 4) begin
                sender_idle_pct    = 0;
                receiver_stall_pct <= 0;
            end
            wait_drained();
            load_settings(plan[seg]);
            items_sent = 0;
            // Each scene usually starts an effect and mostly lets it run, with other events mixed in.
            while (items_sent < ITEMS_PER_SEGMENT) begin
                if ($urandom_range(99) < 85)
                    emit(MODE_SET, EFFECT_W'($urandom_range(7)), LED_W'($urandom_range(7)),
                         time_step());
                else
                    emit(pick_mode(), EFFECT_W'($urandom_range(7)), LED_W'($urandom_range(7)),
                         time_step());
                run = $urandom_range(40, 1);
                repeat (run) begin
                    if ($urandom_range(99) < 85)
                        emit(MODE_TICK, EFFECT_W'($urandom_range(7)),
                             LED_W'($urandom_range(7)), time_step());
                    else
                        emit(pick_mode(), EFFECT_W'($urandom_range(7)),
                             LED_W'($urandom_range(7)), time_step());
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
